### rtl/core/lfu_cache_replacement_assert.svh
// ---------------------------------------------------------------------------
// lfu_cache_replacement_assert.svh
// Assertion macros shared by the LFU store RTL.
// ---------------------------------------------------------------------------
`ifndef LFU_CACHE_REPLACEMENT_ASSERT_SVH
`define LFU_CACHE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LFU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lfu_pkg.sv
// ---------------------------------------------------------------------------
// lfu_pkg
// Shared constants and codes of the LFU key-value store.
// ---------------------------------------------------------------------------
package lfu_pkg;

    // Default sizes
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_COUNT_BITS = 16;

    // Port field widths
    localparam int PORT_KEY_W  = 32;
    localparam int PORT_VAL_W  = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_USED_W  = 66;

    // Capacity register
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // Request queue depth
    localparam int Q_DEPTH = 2;

    // Request kind carried on tuser
    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } t_kind;

endpackage

### rtl/core/lfu_front.sv
// ---------------------------------------------------------------------------
// lfu_front
// Accepts requests, splits them into kind, key and value, and queues them.
// ---------------------------------------------------------------------------
module lfu_front import lfu_pkg::*; #(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // key[31:0], value[63:32]
    input  logic                  s_axis_tuser,   // kind
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output logic                  o_q_put,
    output logic [KEY_BITS-1:0]   o_q_key,
    output logic [VALUE_BITS-1:0] o_q_value
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic                  r_put [Q_DEPTH];
    logic [KEY_BITS-1:0]   r_key [Q_DEPTH];
    logic [VALUE_BITS-1:0] r_val [Q_DEPTH];
    logic [PTR_W-1:0]      r_wptr, r_rptr;
    logic [CNT_W-1:0]      r_cnt;
    logic                  push, pop;

    assign s_axis_tready = (r_cnt != CNT_W'(Q_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != '0);
    assign pop           = i_q_pop && o_q_valid;

    assign o_q_put   = r_put[r_rptr];
    assign o_q_key   = r_key[r_rptr];
    assign o_q_value = r_val[r_rptr];

    // Classify and store the incoming request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_put[r_wptr] <= (t_kind'(s_axis_tuser) == KIND_PUT);
            r_key[r_wptr] <= KEY_BITS'(s_axis_tdata[PORT_KEY_W-1:0]);
            r_val[r_wptr] <= VALUE_BITS'(s_axis_tdata[IN_TDATA_W-1:PORT_KEY_W]);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/core/lfu_engine.sv
// ---------------------------------------------------------------------------
// lfu_engine
// Carries out one request: scans the entry memory, decides hit, fill or
// eviction, sweeps the recency ranks and writes the touched entry.
// ---------------------------------------------------------------------------
`include "lfu_cache_replacement_assert.svh"

module lfu_engine import lfu_pkg::*; #(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CAP_W-1:0]       i_cap,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  logic                   i_q_put,
    input  logic [KEY_BITS-1:0]    i_q_key,
    input  logic [VALUE_BITS-1:0]  i_q_value,
    input  logic                   i_m_tready,
    output logic                   o_m_valid,
    output logic [OUT_TDATA_W-1:0] o_m_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
        logic [IDX_W-1:0]      rank;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_UPD, S_SLOT, S_DONE
    } t_state;

    t_state r_state;

    // Entry memory and valid bits
    t_rec             mem [ENTRIES];
    t_rec             r_rdata;
    logic [ENTRIES-1:0] r_valid;

    // Sweep control
    logic [IDX_W-1:0] r_addr, r_paddr;
    logic             r_issue, r_pv;

    // Request
    logic                  r_put;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;

    // Scan results
    logic                  r_found, r_free_ok, r_vic_ok;
    logic [IDX_W-1:0]      r_fidx, r_free, r_vidx, r_frank, r_vrank;
    logic [VALUE_BITS-1:0] r_fval;
    logic [COUNT_BITS-1:0] r_fcnt, r_vcnt;
    logic [KEY_BITS-1:0]   r_vkey;
    logic [OCC_W-1:0]      r_used;

    // Decision
    logic                  r_hit, r_ev, r_all_inc;
    logic [VALUE_BITS-1:0] r_rd;
    logic [KEY_BITS-1:0]   r_evk;
    logic [IDX_W-1:0]      r_slot, r_thr;
    t_rec                  r_new;

    // Output register
    logic                  r_m_valid, r_m_hit, r_m_ev;
    logic [VALUE_BITS-1:0] r_m_rd;
    logic [KEY_BITS-1:0]   r_m_evk;

    logic [CMP_W-1:0]      cap_eff, cap_x, ent_x;
    logic                  cur_valid, upd_hit, we;
    logic [IDX_W-1:0]      wa;
    t_rec                  wd, bump;
    logic                  vic_better;
    logic [COUNT_BITS-1:0] fcnt_inc;

    assign cap_x   = CMP_W'(i_cap);
    assign ent_x   = CMP_W'(ENTRIES);
    assign cap_eff = (cap_x > ent_x) ? ent_x : cap_x;

    assign cur_valid = r_valid[r_paddr];
    assign vic_better = !r_vic_ok || (r_rdata.count < r_vcnt) ||
                        ((r_rdata.count == r_vcnt) && (r_rdata.rank > r_vrank));
    assign fcnt_inc  = (r_fcnt == '1) ? r_fcnt : r_fcnt + 1'b1;

    // Rank bump for entries swept during the update pass
    assign upd_hit = r_pv && cur_valid && (r_paddr != r_slot) &&
                     (r_all_inc || (r_rdata.rank < r_thr));
    always_comb begin
        bump      = r_rdata;
        bump.rank = r_rdata.rank + 1'b1;
    end

    assign we = ((r_state == S_UPD) && upd_hit) || (r_state == S_SLOT);
    assign wa = (r_state == S_SLOT) ? r_slot : r_paddr;
    assign wd = (r_state == S_SLOT) ? r_new : bump;

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_m_valid = r_m_valid;
    assign o_m_data  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, PORT_KEY_W'(r_m_evk), r_m_ev,
                        PORT_VAL_W'(r_m_rd), r_m_hit};

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[r_addr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_issue   <= 1'b0;
            r_pv      <= 1'b0;
            r_m_valid <= 1'b0;
            r_addr    <= '0;
        end else begin
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            // Read pipeline of the sweeps
            r_pv    <= r_issue;
            r_paddr <= r_addr;
            if (r_issue) begin
                if (r_addr == LAST) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_put     <= i_q_put;
                        r_key     <= i_q_key;
                        r_val     <= i_q_value;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_vic_ok  <= 1'b0;
                        r_used    <= '0;
                        r_addr    <= '0;
                        r_issue   <= 1'b1;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Gather hit, free slot, occupancy and victim
                    if (r_pv) begin
                        if (cur_valid) begin
                            r_used <= r_used + 1'b1;
                            if (!r_found && (r_rdata.key == r_key)) begin
                                r_found <= 1'b1;
                                r_fidx  <= r_paddr;
                                r_fval  <= r_rdata.value;
                                r_fcnt  <= r_rdata.count;
                                r_frank <= r_rdata.rank;
                            end
                            if (vic_better) begin
                                r_vic_ok <= 1'b1;
                                r_vidx   <= r_paddr;
                                r_vcnt   <= r_rdata.count;
                                r_vrank  <= r_rdata.rank;
                                r_vkey   <= r_rdata.key;
                            end
                        end else if (!r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_paddr;
                        end
                        if (r_paddr == LAST) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_hit     <= r_found;
                    r_rd      <= '0;
                    r_ev      <= 1'b0;
                    r_evk     <= '0;
                    r_all_inc <= 1'b0;
                    r_new.key  <= r_key;
                    r_new.rank <= '0;
                    r_addr    <= '0;
                    r_state   <= S_DONE;
                    if (r_found && (!r_put || (cap_eff != '0))) begin
                        // Touch the hit entry
                        r_slot      <= r_fidx;
                        r_thr       <= r_frank;
                        r_new.value <= r_put ? r_val : r_fval;
                        r_new.count <= fcnt_inc;
                        r_rd        <= r_put ? '0 : r_fval;
                        r_issue     <= 1'b1;
                        r_state     <= S_UPD;
                    end else if (r_put && (cap_eff != '0)) begin
                        // Fill, evicting first when full
                        r_new.value <= r_val;
                        r_new.count <= COUNT_BITS'(1);
                        r_issue     <= 1'b1;
                        r_state     <= S_UPD;
                        if (CMP_W'(r_used) >= cap_eff) begin
                            r_ev   <= 1'b1;
                            r_evk  <= r_vkey;
                            r_slot <= r_vidx;
                            r_thr  <= r_vrank;
                        end else begin
                            r_slot    <= r_free;
                            r_thr     <= '0;
                            r_all_inc <= 1'b1;
                        end
                    end
                end
                S_UPD: begin
                    if (r_pv && (r_paddr == LAST)) begin
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    r_valid[r_slot] <= 1'b1;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    // Hand the result to the output register
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_hit   <= r_hit;
                        r_m_rd    <= r_rd;
                        r_m_ev    <= r_ev;
                        r_m_evk   <= r_evk;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `LFU_ASSERT_NOW(a_evict_on_miss, i_clk, i_rst_n, r_m_valid && r_m_ev, !r_m_hit, "eviction reported on a hit")
    `LFU_ASSERT_NOW(a_read_on_hit, i_clk, i_rst_n, r_m_valid && (r_m_rd != '0), r_m_hit && !r_m_ev, "read value without a hit")
    `LFU_ASSERT_NEXT(a_slot_filled, i_clk, i_rst_n, r_state == S_SLOT, r_valid[$past(r_slot)] && (r_state == S_DONE), "slot write did not mark the entry valid")
    `LFU_ASSERT_NEXT(a_scan_order, i_clk, i_rst_n, r_state == S_SCAN, (r_state == S_SCAN) || (r_state == S_DECIDE), "scan left to a wrong state")

endmodule

### rtl/core/lfu_cache_replacement.sv
// ---------------------------------------------------------------------------
// lfu_cache_replacement
// Key-value store with least-frequently-used replacement, ties broken by
// least recent use.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tuser kind; tdata key, value
//  m_axis   | out       | m_axis_tvalid/tready    | tdata hit, read_value, evicted,
//           |           |                         |   evicted_key
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_data capacity
//
//  A request sweeps the entry memory, which has one read and one write port,
//  once to look up and pick a victim, then, unless it is a get miss or an
//  ignored put, once more to age the recency ranks.
//  Reset clears the valid bits at once; there is no clearing pass.
//  A two-deep request queue keeps accepting while the engine works, until it
//  is full, and the output register holds a result until it is taken.
// ---------------------------------------------------------------------------
module lfu_cache_replacement import lfu_pkg::*; #(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key[31:0], value[63:32]
    input  logic                   s_axis_tuser,   // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // hit[0], read_value[32:1],
                                                   // evicted[33], evicted_key[65:34]
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_W-1:0]       i_cfg_data
);

    logic [CAP_W-1:0]      r_capacity;
    logic                  q_valid, q_pop, q_put;
    logic [KEY_BITS-1:0]   q_key;
    logic [VALUE_BITS-1:0] q_value;

    // Capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    lfu_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop),
        .o_q_put       (q_put),
        .o_q_key       (q_key),
        .o_q_value     (q_value)
    );

    lfu_engine #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (r_capacity),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_put    (q_put),
        .i_q_key    (q_key),
        .i_q_value  (q_value),
        .i_m_tready (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_data   (m_axis_tdata)
    );

endmodule

### dv/lfu_cache_replacement_tb.sv
// ---------------------------------------------------------------------------
// lfu_cache_replacement_tb
// Self-checking bench for the LFU key-value store. Gets and puts are driven
// over the request stream under several capacities. A behavioral model of
// the store predicts hit, read value and eviction for each request, and the
// scoreboard checks every response field in order.
// ---------------------------------------------------------------------------
module lfu_cache_replacement_tb import lfu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = DEF_ENTRIES;
    localparam logic [DEF_COUNT_BITS-1:0] COUNT_MAX = '1;

    // Field order follows the response tdata, lowest field last
    typedef struct packed {
        logic [31:0] evicted_key;
        logic        evicted;
        logic [31:0] read_value;
        logic        hit;
    } t_resp;

    // Response scoreboard: holds predicted responses in request order
    class lfu_scoreboard;
        t_resp pending_q[$];
        int    errors;
        int    checked;

        function void note_request(t_resp r);
            pending_q.push_back(r);
        endfunction

        function void check_response(t_resp got);
            t_resp want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected response %h", $realtime, got);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.hit !== want.hit) begin
                errors++;
                $display("%0t: hit exp %b got %b", $realtime, want.hit, got.hit);
            end
            if (got.read_value !== want.read_value) begin
                errors++;
                $display("%0t: read_value exp %h got %h", $realtime,
                         want.read_value, got.read_value);
            end
            if (got.evicted !== want.evicted) begin
                errors++;
                $display("%0t: evicted exp %b got %b", $realtime,
                         want.evicted, got.evicted);
            end
            if (got.evicted_key !== want.evicted_key) begin
                errors++;
                $display("%0t: evicted_key exp %h got %h", $realtime,
                         want.evicted_key, got.evicted_key);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CAP_W-1:0]       i_cfg_data = '0;

    lfu_cache_replacement i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Model state of the store
    logic [CAP_W-1:0]          model_cap;
    logic                      slot_valid [NSLOT];
    logic [31:0]               slot_key   [NSLOT];
    logic [31:0]               slot_value [NSLOT];
    logic [DEF_COUNT_BITS-1:0] slot_uses  [NSLOT];
    int unsigned               slot_age   [NSLOT];

    lfu_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_evict = 0;
    int n_hit = 0;
    logic [31:0] key_pool [8];

    // Make a slot the most recent and bump its use count
    function automatic void promote_slot(int s);
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
        slot_age[s] = 0;
        if (slot_uses[s] != COUNT_MAX) slot_uses[s]++;
    endfunction

    // Predict the response to one request and advance the model
    function automatic t_resp predict_lookup(t_kind kind, logic [31:0] key,
                                             logic [31:0] value);
        t_resp r;
        int found, free_s, victim, used, cap;
        r = '0;
        found = -1; free_s = -1; victim = -1; used = 0;
        cap = (model_cap > NSLOT) ? NSLOT : model_cap;
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_valid[i]) begin
                used++;
                if (found < 0 && slot_key[i] == key) found = i;
            end else if (free_s < 0) begin
                free_s = i;
            end
        end
        r.hit = (found >= 0);
        if (kind == KIND_GET) begin
            if (found >= 0) begin
                r.read_value = slot_value[found];
                promote_slot(found);
            end
        end else if (cap != 0) begin
            if (found >= 0) begin
                slot_value[found] = value;
                promote_slot(found);
            end else begin
                if (used >= cap) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!slot_valid[i]) continue;
                        if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                            (slot_uses[i] == slot_uses[victim] &&
                             slot_age[i] > slot_age[victim]))
                            victim = i;
                    end
                    if (victim >= 0) begin
                        r.evicted = 1'b1;
                        r.evicted_key = slot_key[victim];
                        slot_valid[victim] = 1'b0;
                        for (int i = 0; i < NSLOT; i++)
                            if (slot_valid[i] && slot_age[i] > slot_age[victim])
                                slot_age[i]--;
                        free_s = victim;
                    end
                end
                if (free_s >= 0) begin
                    for (int i = 0; i < NSLOT; i++)
                        if (slot_valid[i]) slot_age[i]++;
                    slot_valid[free_s] = 1'b1;
                    slot_key[free_s] = key;
                    slot_value[free_s] = value;
                    slot_uses[free_s] = 1;
                    slot_age[free_s] = 0;
                end
            end
        end
        return r;
    endfunction

    // Send one request, idling at random beforehand; valid stays high after
    // the accept until the next request or an idle cycle replaces it
    task automatic send_request(t_kind kind, logic [31:0] key, logic [31:0] value);
        t_resp r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {value, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = predict_lookup(kind, key, value);
        if (r.hit) n_hit++;
        if (r.evicted) n_evict++;
        sb.note_request(r);
    endtask

    // Drop valid, wait for every pending response, then let the engine go quiet
    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (2 * NSLOT + 10) @(posedge i_clk);
    endtask

    // Write the capacity register while idle
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_responses();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_cap = cap;
        i_cfg_valid <= 1'b0;
    endtask

    // Random request biased toward a small key pool so hits and ties happen
    task automatic send_random();
        t_kind kind;
        logic [31:0] key;
        kind = ($urandom_range(99) < 55) ? KIND_PUT : KIND_GET;
        key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom();
        send_request(kind, key, $urandom());
    endtask

    // Response side: random stalls, check on each accepted response
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_response(t_resp'(m_axis_tdata[OUT_USED_W-1:0]));
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        model_cap = CAP_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_uses[i] = '0;
            slot_age[i] = 0;
        end
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, get miss, put fill, hits, full-store eviction
        send_request(KIND_GET, 32'h0, 32'hFFFF_FFFF);
        send_request(KIND_PUT, 32'h0, 32'hFFFF_FFFF);
        send_request(KIND_PUT, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_GET, 32'h0, 32'h0);
        send_request(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_PUT, 32'h0, 32'hA5A5_5A5A);
        write_capacity(5'd2);
        // Capacity two: each new key evicts the entry with the lowest count
        send_request(KIND_PUT, 32'h1234_5678, 32'h1);
        send_request(KIND_PUT, 32'h8765_4321, 32'h2);
        send_request(KIND_PUT, 32'h5555_AAAA, 32'h3);
        write_capacity(5'd0);
        // Capacity zero: puts ignored, gets still work
        send_request(KIND_PUT, 32'hDEAD_BEEF, 32'h4);
        send_request(KIND_PUT, 32'h5555_AAAA, 32'h5);
        send_request(KIND_GET, 32'h5555_AAAA, 32'h0);
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++) send_request(KIND_PUT, $urandom(), $urandom());

        // Random phases with different capacities and idling mixes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_capacity(5'd16); send_idle_pct = 27; recv_idle_pct = 50; end
                1: begin write_capacity(5'd3); end
                2: begin write_capacity(5'd1); send_idle_pct = 50; recv_idle_pct = 27; end
                3: begin write_capacity(5'd0); end
                4: begin write_capacity(5'd8); send_idle_pct = 0; recv_idle_pct = 0; end
                default: begin write_capacity(5'd17); end
            endcase
            for (int i = 0; i < 155; i++) begin
                send_random();
                if (i == 77) drain_responses();
            end
        end

        drain_responses();
        $display("Checked %0d responses: %0d hits, %0d evictions, capacities 0..31.",
                 sb.checked, n_hit, n_evict);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("lfu_cache_replacement test passed");
        else
            $display("lfu_cache_replacement test failed");
        $finish;
    end

    // Run limit
    initial begin
        #5ms;
        $display("lfu_cache_replacement test failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lfu_pkg.sv
rtl/core/lfu_front.sv
rtl/core/lfu_engine.sv
rtl/core/lfu_cache_replacement.sv
dv/lfu_cache_replacement_tb.sv
